// ===== design/aabb_sphere_contact_defines.svh =====
`ifndef AABB_SPHERE_CONTACT_DEFINES_SVH
`define AABB_SPHERE_CONTACT_DEFINES_SVH

// same-cycle check, sampled on clk, off while rst_n is low
`define ASC_ASSERT(name, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// check in the cycle after the trigger
`define ASC_ASSERT_NEXT(name, trig, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (prop)) \
        else $error(msg);

`endif

// ===== design/asc_pkg.sv =====
`timescale 1ns / 1ps

package asc_pkg;

    localparam int COORD_BITS_DEF = 24;

    typedef enum logic [1:0] {
        AXIS_X,
        AXIS_Y,
        AXIS_Z
    } asc_axis_t;

    typedef struct packed {
        logic far;
        logic gt;
    } asc_flags_t;

endpackage

// ===== design/asc_pair_if.sv =====
`timescale 1ns / 1ps

interface asc_pair_if #(
    parameter int COORD_BITS = asc_pkg::COORD_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] box_x;
    logic signed [COORD_BITS-1:0] box_y;
    logic signed [COORD_BITS-1:0] box_z;
    logic        [COORD_BITS-2:0] half_x;
    logic        [COORD_BITS-2:0] half_y;
    logic        [COORD_BITS-2:0] half_z;
    logic signed [COORD_BITS-1:0] sphere_x;
    logic signed [COORD_BITS-1:0] sphere_y;
    logic signed [COORD_BITS-1:0] sphere_z;
    logic        [COORD_BITS-2:0] radius;
    logic                         sphere_asks;

    modport source (
        output valid, box_x, box_y, box_z, half_x, half_y, half_z,
               sphere_x, sphere_y, sphere_z, radius, sphere_asks,
        input  ready
    );

    modport sink (
        input  valid, box_x, box_y, box_z, half_x, half_y, half_z,
               sphere_x, sphere_y, sphere_z, radius, sphere_asks,
        output ready
    );
endinterface

// ===== design/asc_contact_if.sv =====
`timescale 1ns / 1ps

interface asc_contact_if #(
    parameter int COORD_BITS = asc_pkg::COORD_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic                  hit;
    logic [1:0]            normal_axis;
    logic                  normal_negative;
    logic [COORD_BITS:0]   penetration;

    modport source (
        output valid, hit, normal_axis, normal_negative, penetration,
        input  ready
    );

    modport sink (
        input  valid, hit, normal_axis, normal_negative, penetration,
        output ready
    );
endinterface

// ===== design/aabb_sphere_contact.sv =====
// aabb_sphere_contact: box versus sphere contact test
// pair channel (sink) takes one beat per box/sphere pair: box center, half
// extents, sphere center, radius, all fixed point with 12 fraction bits, and
// the sphere_asks flag that flips the normal sign
// contact channel (source) gives one beat per pair: hit, axis of least
// overlap, normal sign and penetration depth; all zero on a miss
// contact.valid trails the pair through five register stages, the first
// loading at the accepting edge: interval ends, clamp distance and overlap,
// squares, partial sum with axis pick, and the final sum and compare in the
// output register
// throughput is one pair per cycle; all stages share one advance enable, so
// pair.ready is high whenever the output register is empty or being taken
// a stall on contact.ready freezes the whole pipeline in place and drops
// pair.ready in the same cycle; nothing is lost or repeated
// reset clears the stage valid bits and the output valid; payload registers
// are not reset
`timescale 1ns / 1ps
`include "aabb_sphere_contact_defines.svh"

module aabb_sphere_contact #(
    parameter int COORD_BITS = asc_pkg::COORD_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    asc_pair_if.sink       pair,
    asc_contact_if.source  contact
);

    localparam int H    = COORD_BITS - 1;
    localparam int OW   = COORD_BITS + 2;
    localparam int PW   = COORD_BITS + 1;
    localparam int SQ   = 2 * (COORD_BITS - 1);
    localparam int SUMW = 2 * COORD_BITS;

    logic adv;
    logic [3:0] v_reg;
    logic out_valid_reg;

    assign adv        = !out_valid_reg || contact.ready;
    assign pair.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg         <= {v_reg[2:0], pair.valid};
            out_valid_reg <= v_reg[3];
        end
    end

    // per-axis front end, stages 1 to 3
    logic signed [COORD_BITS-1:0] c_in [3];
    logic        [H-1:0]          h_in [3];
    logic signed [COORD_BITS-1:0] s_in [3];
    logic        [SQ-1:0]         sq   [3];
    logic signed [OW-1:0]         ov   [3];
    asc_pkg::asc_flags_t          flags [3];

    assign c_in[0] = pair.box_x;
    assign c_in[1] = pair.box_y;
    assign c_in[2] = pair.box_z;
    assign h_in[0] = pair.half_x;
    assign h_in[1] = pair.half_y;
    assign h_in[2] = pair.half_z;
    assign s_in[0] = pair.sphere_x;
    assign s_in[1] = pair.sphere_y;
    assign s_in[2] = pair.sphere_z;

    for (genvar a = 0; a < 3; a++)
    begin : g_axis
        asc_axis #(
            .COORD_BITS (COORD_BITS)
        ) u_axis (
            .clk   (clk),
            .en    (adv),
            .c     (c_in[a]),
            .h     (h_in[a]),
            .s     (s_in[a]),
            .r     (pair.radius),
            .sq    (sq[a]),
            .ov    (ov[a]),
            .flags (flags[a])
        );
    end

    // radius square and caller flag, aligned with the axis outputs
    logic [H-1:0]  r1_reg;
    logic [H-1:0]  r2_reg;
    logic [SQ-1:0] rsq3_reg;
    logic [2:0]    asks_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            r1_reg   <= pair.radius;
            r2_reg   <= r1_reg;
            rsq3_reg <= SQ'(r2_reg) * SQ'(r2_reg);
            asks_reg <= {asks_reg[1:0], pair.sphere_asks};
        end
    end

    // stage 4: partial sum, far flag, least overlap axis
    asc_pkg::asc_axis_t   b1;
    asc_pkg::asc_axis_t   best;
    logic signed [OW-1:0] ov_b1;
    logic signed [OW-1:0] ov_best;
    logic                 gt_best;

    always_comb
    begin
        if (ov[0] > ov[1])
        begin
            b1    = asc_pkg::AXIS_Y;
            ov_b1 = ov[1];
        end
        else
        begin
            b1    = asc_pkg::AXIS_X;
            ov_b1 = ov[0];
        end
        if (ov_b1 > ov[2])
        begin
            best    = asc_pkg::AXIS_Z;
            ov_best = ov[2];
        end
        else
        begin
            best    = b1;
            ov_best = ov_b1;
        end
        case (best)
            asc_pkg::AXIS_X: gt_best = flags[0].gt;
            asc_pkg::AXIS_Y: gt_best = flags[1].gt;
            default:         gt_best = flags[2].gt;
        endcase
    end

    logic [SQ:0]          psum_reg;
    logic [SQ-1:0]        sqz_reg;
    logic [SQ-1:0]        rsq4_reg;
    logic                 far_reg;
    asc_pkg::asc_axis_t   best_reg;
    logic signed [OW-1:0] ov_best_reg;
    logic                 neg_reg;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            psum_reg    <= (SQ+1)'(sq[0]) + (SQ+1)'(sq[1]);
            sqz_reg     <= sq[2];
            rsq4_reg    <= rsq3_reg;
            far_reg     <= flags[0].far || flags[1].far || flags[2].far;
            best_reg    <= best;
            ov_best_reg <= ov_best;
            neg_reg     <= gt_best ^ asks_reg[2];
        end
    end

    // stage 5: full sum against squared radius, output register
    logic [SUMW-1:0] sum;
    logic            hit_next;
    logic            hit_reg;
    logic [1:0]      axis_reg;
    logic            neg_out_reg;
    logic [PW-1:0]   pen_reg;

    assign sum      = SUMW'(psum_reg) + SUMW'(sqz_reg);
    assign hit_next = !far_reg && (sum <= SUMW'(rsq4_reg));

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            hit_reg <= hit_next;
            if (hit_next)
            begin
                axis_reg    <= best_reg;
                neg_out_reg <= neg_reg;
                pen_reg     <= ov_best_reg[OW-1] ? '0 : ov_best_reg[PW-1:0];
            end
            else
            begin
                axis_reg    <= asc_pkg::AXIS_X;
                neg_out_reg <= 1'b0;
                pen_reg     <= '0;
            end
        end
    end

    assign contact.valid           = out_valid_reg;
    assign contact.hit             = hit_reg;
    assign contact.normal_axis     = axis_reg;
    assign contact.normal_negative = neg_out_reg;
    assign contact.penetration     = pen_reg;

    `ASC_ASSERT(a_miss_zero,
        contact.valid && !contact.hit |-> contact.normal_axis == asc_pkg::AXIS_X &&
            !contact.normal_negative && contact.penetration == '0,
        "miss beat carries nonzero fields")
    `ASC_ASSERT_NEXT(a_stall_hold, !adv,
        $stable(v_reg) && $stable(out_valid_reg), "pipeline moved during stall")
    `ASC_ASSERT(a_out_source, $rose(out_valid_reg) |-> $past(v_reg[3]) && $past(adv),
        "output valid without last stage beat")

endmodule

// ===== design/asc_axis.sv =====
`timescale 1ns / 1ps

module asc_axis #(
    parameter int COORD_BITS = asc_pkg::COORD_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              en,
    input  logic signed [COORD_BITS-1:0]      c,
    input  logic        [COORD_BITS-2:0]      h,
    input  logic signed [COORD_BITS-1:0]      s,
    input  logic        [COORD_BITS-2:0]      r,
    output logic        [2*COORD_BITS-3:0]    sq,
    output logic signed [COORD_BITS+1:0]      ov,
    output asc_pkg::asc_flags_t               flags
);

    localparam int H  = COORD_BITS - 1;
    localparam int E  = COORD_BITS + 1;
    localparam int OW = COORD_BITS + 2;
    localparam int SQ = 2 * (COORD_BITS - 1);

    // stage 1: interval ends
    logic signed [E-1:0] c_e;
    logic signed [E-1:0] h_e;
    logic signed [E-1:0] s_e;
    logic signed [E-1:0] r_e;
    logic signed [E-1:0] lo_box_reg;
    logic signed [E-1:0] hi_box_reg;
    logic signed [E-1:0] lo_sph_reg;
    logic signed [E-1:0] hi_sph_reg;
    logic signed [E-1:0] s1_reg;
    logic        [H-1:0] r1_reg;
    logic                gt1_reg;

    assign c_e = E'(c);
    assign s_e = E'(s);
    assign h_e = signed'(E'(h));
    assign r_e = signed'(E'(r));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_box_reg <= c_e - h_e;
            hi_box_reg <= c_e + h_e;
            lo_sph_reg <= s_e - r_e;
            hi_sph_reg <= s_e + r_e;
            s1_reg     <= s_e;
            r1_reg     <= r;
            gt1_reg    <= (c > s);
        end
    end

    // stage 2: clamp distance and interval overlap
    logic                below;
    logic                above;
    logic        [E-1:0] d_next;
    logic signed [E-1:0] hi_min;
    logic signed [E-1:0] lo_max;
    logic signed [OW-1:0] ov_next;
    logic        [H-1:0] d_reg;
    logic signed [OW-1:0] ov2_reg;
    asc_pkg::asc_flags_t flags2_reg;

    always_comb
    begin
        below  = (s1_reg < lo_box_reg);
        above  = (s1_reg > hi_box_reg);
        if (below)
        begin
            d_next = unsigned'(lo_box_reg - s1_reg);
        end
        else if (above)
        begin
            d_next = unsigned'(s1_reg - hi_box_reg);
        end
        else
        begin
            d_next = '0;
        end
        hi_min  = (hi_box_reg < hi_sph_reg) ? hi_box_reg : hi_sph_reg;
        lo_max  = (lo_box_reg > lo_sph_reg) ? lo_box_reg : lo_sph_reg;
        ov_next = OW'(hi_min) - OW'(lo_max);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_reg          <= d_next[H-1:0];
            ov2_reg        <= ov_next;
            flags2_reg.far <= (d_next > E'(r1_reg));
            flags2_reg.gt  <= gt1_reg;
        end
    end

    // stage 3: squared distance
    logic [SQ-1:0] sq_reg;
    logic signed [OW-1:0] ov3_reg;
    asc_pkg::asc_flags_t flags3_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sq_reg     <= SQ'(d_reg) * SQ'(d_reg);
            ov3_reg    <= ov2_reg;
            flags3_reg <= flags2_reg;
        end
    end

    assign sq    = sq_reg;
    assign ov    = ov3_reg;
    assign flags = flags3_reg;

endmodule

// ===== tb/sv/aabb_sphere_contact_checker.sv =====
`timescale 1ns / 1ps

module aabb_sphere_contact_checker (
    input  logic   clk,
    input  logic   rst_n,
    asc_pair_if    pair,
    asc_contact_if contact,
    output int     fail_count,
    output int     pending_count
);
    import asc_pkg::*;

    localparam int CB = COORD_BITS_DEF;

    typedef struct packed {
        logic signed [CB-1:0] box_x;
        logic signed [CB-1:0] box_y;
        logic signed [CB-1:0] box_z;
        logic        [CB-2:0] half_x;
        logic        [CB-2:0] half_y;
        logic        [CB-2:0] half_z;
        logic signed [CB-1:0] sphere_x;
        logic signed [CB-1:0] sphere_y;
        logic signed [CB-1:0] sphere_z;
        logic        [CB-2:0] radius;
        logic                 sphere_asks;
    } pair_beat_t;

    typedef struct {
        logic          hit;
        asc_axis_t     axis;
        logic          negative;
        logic [CB:0]   depth;
    } contact_t;

    contact_t expected_contacts[$];
    int       fails = 0;
    int       pending = 0;

    assign fail_count    = fails;
    assign pending_count = pending;

    function automatic contact_t contact_of(input pair_beat_t b);
        contact_t          res;
        longint            c[3];
        longint            h[3];
        longint            s[3];
        longint            ov[3];
        longint            r;
        longint            lo;
        longint            hi;
        longint            d;
        longint unsigned   dist_sq;
        logic              far;
        int                best;
        res.hit      = 1'b0;
        res.axis     = AXIS_X;
        res.negative = 1'b0;
        res.depth    = '0;
        c[0] = longint'(b.box_x);
        c[1] = longint'(b.box_y);
        c[2] = longint'(b.box_z);
        h[0] = longint'(b.half_x);
        h[1] = longint'(b.half_y);
        h[2] = longint'(b.half_z);
        s[0] = longint'(b.sphere_x);
        s[1] = longint'(b.sphere_y);
        s[2] = longint'(b.sphere_z);
        r    = longint'(b.radius);
        dist_sq = 0;
        far     = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            lo = c[i] - h[i];
            hi = c[i] + h[i];
            d  = 0;
            if (s[i] < lo)
                d = lo - s[i];
            else if (s[i] > hi)
                d = s[i] - hi;
            if (d > r)
                far = 1'b1;
            else
                dist_sq += longint'(unsigned'(d * d));
        end
        if (far || dist_sq > longint'(unsigned'(r * r)))
            return res;
        for (int i = 0; i < 3; i++)
        begin
            hi    = (c[i] + h[i] < s[i] + r) ? c[i] + h[i] : s[i] + r;
            lo    = (c[i] - h[i] > s[i] - r) ? c[i] - h[i] : s[i] - r;
            ov[i] = hi - lo;
        end
        // least overlap, ties keep the lower axis
        best = 0;
        for (int ax = 1; ax < 3; ax++)
            if (ov[best] > ov[ax])
                best = ax;
        res.hit      = 1'b1;
        res.axis     = asc_axis_t'(best);
        res.negative = ((c[best] - s[best]) > 0) ^ b.sphere_asks;
        res.depth    = (ov[best] < 0) ? '0 : ov[best][CB:0];
        return res;
    endfunction

    always @(posedge clk)
    begin
        contact_t   want;
        pair_beat_t beat;
        if (rst_n === 1'b1)
        begin
            if (contact.valid === 1'b1 && contact.ready === 1'b1)
            begin
                if (expected_contacts.size() == 0)
                begin
                    $error("contact beat with no pair outstanding");
                    fails++;
                end
                else
                begin
                    want = expected_contacts.pop_front();
                    if (contact.hit !== want.hit)
                    begin
                        $error("hit: expected %0d, got %0d", want.hit, contact.hit);
                        fails++;
                    end
                    if (contact.normal_axis !== want.axis)
                    begin
                        $error("normal_axis: expected %0d, got %0d",
                               want.axis, contact.normal_axis);
                        fails++;
                    end
                    if (contact.normal_negative !== want.negative)
                    begin
                        $error("normal_negative: expected %0d, got %0d",
                               want.negative, contact.normal_negative);
                        fails++;
                    end
                    if (contact.penetration !== want.depth)
                    begin
                        $error("penetration: expected %0d, got %0d",
                               want.depth, contact.penetration);
                        fails++;
                    end
                end
            end
            if (pair.valid === 1'b1 && pair.ready === 1'b1)
            begin
                beat = '{pair.box_x, pair.box_y, pair.box_z,
                         pair.half_x, pair.half_y, pair.half_z,
                         pair.sphere_x, pair.sphere_y, pair.sphere_z,
                         pair.radius, pair.sphere_asks};
                expected_contacts.push_back(contact_of(beat));
            end
            pending = expected_contacts.size();
        end
    end

endmodule

// ===== tb/sv/aabb_sphere_contact_tb.sv =====
`timescale 1ns / 1ps

module aabb_sphere_contact_tb;
    import asc_pkg::*;

    localparam int                   CB           = COORD_BITS_DEF;
    localparam int                   HB           = CB - 1;
    localparam logic signed [CB-1:0] CMAX         = {1'b0, {(CB - 1){1'b1}}};
    localparam logic signed [CB-1:0] CMIN         = {1'b1, {(CB - 1){1'b0}}};
    localparam logic        [HB-1:0] HMAX         = '1;
    localparam int                   RANDOM_PAIRS = 500;
    localparam int                   CALM_TAIL    = 100;
    localparam int                   HOLD_AT      = 150;
    localparam int                   PAUSE_AT     = 300;
    localparam int                   HOLD_CYCLES  = 40;
    localparam int                   DRAIN_CYCLES = 20;

    typedef struct packed {
        logic signed [CB-1:0] box_x;
        logic signed [CB-1:0] box_y;
        logic signed [CB-1:0] box_z;
        logic        [CB-2:0] half_x;
        logic        [CB-2:0] half_y;
        logic        [CB-2:0] half_z;
        logic signed [CB-1:0] sphere_x;
        logic signed [CB-1:0] sphere_y;
        logic signed [CB-1:0] sphere_z;
        logic        [CB-2:0] radius;
        logic                 sphere_asks;
    } pair_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   fail_count;
    int   pending_count;
    bit   source_idles = 1'b1;
    bit   sink_idles = 1'b1;
    bit   hold_off_req = 1'b0;

    asc_pair_if    pair ();
    asc_contact_if contact ();

    aabb_sphere_contact u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .pair    (pair.sink),
        .contact (contact.source)
    );

    aabb_sphere_contact_checker u_contact_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .pair          (pair),
        .contact       (contact),
        .fail_count    (fail_count),
        .pending_count (pending_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic send_pair(input pair_t p);
        if (source_idles && $urandom_range(0, 3) == 0)
        begin
            pair.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        pair.box_x       <= p.box_x;
        pair.box_y       <= p.box_y;
        pair.box_z       <= p.box_z;
        pair.half_x      <= p.half_x;
        pair.half_y      <= p.half_y;
        pair.half_z      <= p.half_z;
        pair.sphere_x    <= p.sphere_x;
        pair.sphere_y    <= p.sphere_y;
        pair.sphere_z    <= p.sphere_z;
        pair.radius      <= p.radius;
        pair.sphere_asks <= p.sphere_asks;
        pair.valid       <= 1'b1;
        @(negedge clk);
        while (pair.ready !== 1'b1)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic wait_drained();
        pair.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending_count != 0);
        @(posedge clk);
    endtask

    function automatic pair_t random_pair();
        pair_t  p;
        longint c[3];
        longint h[3];
        longint s[3];
        longint r;
        longint span;
        int     sh;
        bit     tie;
        if ($urandom_range(0, 7) == 0)
        begin
            p.box_x       = CB'($urandom);
            p.box_y       = CB'($urandom);
            p.box_z       = CB'($urandom);
            p.half_x      = HB'($urandom);
            p.half_y      = HB'($urandom);
            p.half_z      = HB'($urandom);
            p.sphere_x    = CB'($urandom);
            p.sphere_y    = CB'($urandom);
            p.sphere_z    = CB'($urandom);
            p.radius      = HB'($urandom);
            p.sphere_asks = 1'($urandom);
            return p;
        end
        // near pair: sphere center placed around the box at a random scale
        sh  = $urandom_range(1, HB);
        tie = ($urandom_range(0, 3) == 0);
        r   = longint'($urandom) & ((longint'(1) << $urandom_range(0, HB)) - 1);
        for (int i = 0; i < 3; i++)
        begin
            c[i] = longint'($urandom_range(0, 2 ** CB - 1)) + CMIN;
            if (tie && i > 0)
                h[i] = h[0];
            else
                h[i] = longint'($urandom) & ((longint'(1) << sh) - 1);
            span = h[i] + r + (h[i] + r) / 4 + 1;
            s[i] = c[i] + longint'($urandom_range(0, 32'(2 * span))) - span;
            if (s[i] > CMAX)
                s[i] = CMAX;
            if (s[i] < CMIN)
                s[i] = CMIN;
        end
        p.box_x       = CB'(c[0]);
        p.box_y       = CB'(c[1]);
        p.box_z       = CB'(c[2]);
        p.half_x      = HB'(h[0]);
        p.half_y      = HB'(h[1]);
        p.half_z      = HB'(h[2]);
        p.sphere_x    = CB'(s[0]);
        p.sphere_y    = CB'(s[1]);
        p.sphere_z    = CB'(s[2]);
        p.radius      = HB'(r);
        p.sphere_asks = 1'($urandom);
        return p;
    endfunction

    // receiver
    initial
    begin
        contact.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_off_req)
            begin
                contact.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end
            else if (sink_idles && $urandom_range(0, 3) == 0)
            begin
                contact.ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            else
            begin
                contact.ready <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // sender
    initial
    begin
        pair.valid       = 1'b0;
        pair.box_x       = '0;
        pair.box_y       = '0;
        pair.box_z       = '0;
        pair.half_x      = '0;
        pair.half_y      = '0;
        pair.half_z      = '0;
        pair.sphere_x    = '0;
        pair.sphere_y    = '0;
        pair.sphere_z    = '0;
        pair.radius      = '0;
        pair.sphere_asks = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // degenerate point pair, both callers
        send_pair('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0});
        send_pair('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1});
        // far apart, miss ignores the caller flag
        send_pair('{CMAX, CMAX, CMAX, 0, 0, 0, CMIN, CMIN, CMIN, 0, 1});
        // full range, one lsb too far on every axis
        send_pair('{CMIN, CMIN, CMIN, HMAX, HMAX, HMAX, CMAX, CMAX, CMAX, HMAX, 0});
        // full range, deepest overlap
        send_pair('{CMAX, CMAX, CMAX, HMAX, HMAX, HMAX, CMAX, CMAX, CMAX, HMAX, 1});
        send_pair('{CMIN, CMIN, CMIN, HMAX, HMAX, HMAX, CMIN, CMIN, CMIN, HMAX, 0});
        // touching a face on either side
        send_pair('{0, 0, 0, 4096, 4096, 4096, 8192, 0, 0, 4096, 0});
        send_pair('{0, 0, 0, 4096, 4096, 4096, -8192, 0, 0, 4096, 1});
        // touching an edge, then one lsb short
        send_pair('{0, 0, 0, 4096, 4096, 4096, 7168, 8192, 0, 5120, 0});
        send_pair('{0, 0, 0, 4096, 4096, 4096, 7168, 8192, 0, 5119, 0});
        // y and z tie
        send_pair('{0, 0, 0, 8192, 4096, 4096, 0, 0, 0, 20000, 0});
        // least overlap on z and on y, box beyond sphere
        send_pair('{0, 0, 0, 8192, 8192, 8192, 0, 0, -10000, 4096, 0});
        send_pair('{0, 0, 0, 8192, 8192, 8192, 0, 0, -10000, 4096, 1});
        send_pair('{0, 0, 0, 8192, 8192, 8192, 0, -7000, 0, 4096, 0});
        // zero radius inside box, zero box inside sphere, center in box
        send_pair('{100, -100, 50, 1000, 1000, 1000, 100, -100, 50, 0, 0});
        send_pair('{CMIN, 0, CMAX, 0, 0, 0, CMIN + CB'(10), 0, CMAX - CB'(10), 20, 1});
        send_pair('{-1, 1, CMIN + CB'(1), 1, HMAX, 2, 0, CMAX, CMIN, 3, 1});
        wait_drained();

        for (int i = 0; i < RANDOM_PAIRS; i++)
        begin
            if (i == HOLD_AT)
            begin
                source_idles = 1'b0;
                hold_off_req = 1'b1;
            end
            if (i == HOLD_AT + 30)
                source_idles = 1'b1;
            if (i == PAUSE_AT)
                wait_drained();
            if (i == RANDOM_PAIRS - CALM_TAIL)
            begin
                source_idles = 1'b0;
                sink_idles   = 1'b0;
            end
            send_pair(random_pair());
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("aabb_sphere_contact test passed");
        else
            $display("aabb_sphere_contact test failed");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("aabb_sphere_contact test failed");
        $finish;
    end

endmodule
